// File: src/tach_pkg.sv
// shared types and constants for the tachometer rpm averager
`timescale 1ns / 1ps

package tach_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TALLY_W    = 16;
  localparam int unsigned RPM_W      = 15;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned POLES_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned DEN_W      = TIME_W + POLES_W;

  localparam logic [TALLY_W-1:0]    MS_PER_MINUTE = 16'd60000;
  localparam logic [TALLY_W-1:0]    TALLY_LIMIT   = 16'hFFFF;
  localparam logic [RPM_W-1:0]      RPM_LIMIT     = 15'h7FFF;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET  = 16'd500;
  localparam logic [POLES_W-1:0]    POLES_RESET   = 8'd1;

  localparam logic [CFG_IDX_W-1:0]  REG_REFRESH_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_POLE_COUNT     = 2'd1;

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             updated;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: src/tach_div.sv
// bit-serial restoring divider with quotient saturated to the rpm range
`timescale 1ns / 1ps

module tach_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tach_pkg::NUM_W-1:0] num,
  input  logic [tach_pkg::DEN_W-1:0] den,
  output tach_pkg::div_stat_t        stat,
  output logic [tach_pkg::RPM_W-1:0] rate
);
  import tach_pkg::*;

  localparam int unsigned Q_W   = RPM_W + 1;
  localparam int unsigned D_W   = DEN_W + RPM_W;
  localparam int unsigned CNT_W = $clog2(Q_W);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [D_W-1:0]   d_r, d_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             fits;
  logic [NUM_W-1:0] diff;

  // divisor is shifted right each step, remainder stays below 2^32
  assign fits = {{(D_W-NUM_W){1'b0}}, rem_r} >= d_r;
  assign diff = rem_r - d_r[NUM_W-1:0];

  always_comb begin
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      d_nxt    = {den, {RPM_W{1'b0}}};
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(Q_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = diff;
      end
      q_nxt = {q_r[Q_W-2:0], fits};
      d_nxt = d_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  // top quotient bit set means the true quotient is at least 32768
  assign rate      = q_r[Q_W-1] ? RPM_LIMIT : q_r[RPM_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: src/tachometer_rpm_averager.sv
// tachometer rpm over a time gate, averaged with the previous reading
//
//   channel | direction | handshake              | word
//   in_     | in        | in_valid / in_ready    | operation, now_ms
//   out_    | out       | out_valid / out_ready  | rpm, updated
//   cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a pulse word gives no result
// a poll that does not close the gate goes through the check and out states
// a poll that closes the gate makes two passes through the shared
// multiplier, then 16 steps of the bit-serial divider set the figure
// reset is synchronous: control registers reset, nothing pending
// in_ready is low while a poll is in work and while a result cannot be loaded
`timescale 1ns / 1ps

module tachometer_rpm_averager (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tach_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tach_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tach_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tach_pkg::*;

  localparam int unsigned PROD_W = TIME_W + TALLY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_NUM,
    S_MUL_DEN,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [POLES_W-1:0]  poles_r, poles_nxt;
  logic [TALLY_W-1:0]  tally_r, tally_nxt;
  logic [TIME_W-1:0]   gate_r, gate_nxt;
  logic [RPM_W-1:0]    prev_r, prev_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_acc;
  logic                div_start;
  div_stat_t           div_stat;
  logic [RPM_W-1:0]    div_rate;
  logic [POLES_W-1:0]  poles_eff;
  logic [TIME_W-1:0]   mul_a;
  logic [TALLY_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;
  logic [RPM_W:0]      avg_sum;
  logic                gate_close;
  logic                out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign poles_eff = (poles_r == '0) ? POLES_W'(1) : poles_r;

  // one multiplier serves both the numerator and the divisor
  always_comb begin
    if (state_r == S_MUL_NUM) begin
      mul_a = TIME_W'(tally_r);
      mul_b = MS_PER_MINUTE;
    end else begin
      mul_a = elapsed_r;
      mul_b = TALLY_W'(poles_eff);
    end
  end
  assign prod = mul_a * mul_b;

  assign div_start  = (state_r == S_MUL_DEN);
  assign gate_close = (elapsed_r >= TIME_W'(period_r)) && (elapsed_r != '0);
  assign avg_sum    = {1'b0, div_rate} + {1'b0, prev_r};
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_ready);

  tach_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (prod[DEN_W-1:0]),
    .stat  (div_stat),
    .rate  (div_rate)
  );

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    poles_nxt     = poles_r;
    tally_nxt     = tally_r;
    gate_nxt      = gate_r;
    prev_nxt      = prev_r;
    now_nxt       = now_r;
    elapsed_nxt   = elapsed_r;
    num_nxt       = num_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REFRESH_PERIOD: period_nxt = cfg_data[PERIOD_W-1:0];
        REG_POLE_COUNT:     poles_nxt  = cfg_data[POLES_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.operation == OP_PULSE) begin
            if (tally_r != TALLY_LIMIT) begin
              tally_nxt = tally_r + 1'b1;
            end
          end else begin
            now_nxt     = in_data.now_ms;
            elapsed_nxt = in_data.now_ms - gate_r;
            state_nxt   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (gate_close) begin
          state_nxt = S_MUL_NUM;
        end else begin
          res_nxt.rpm     = prev_r;
          res_nxt.updated = 1'b0;
          state_nxt       = S_OUT;
        end
      end
      S_MUL_NUM: begin
        num_nxt   = prod[NUM_W-1:0];
        state_nxt = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          prev_nxt        = avg_sum[RPM_W:1];
          tally_nxt       = '0;
          gate_nxt        = now_r;
          res_nxt.rpm     = avg_sum[RPM_W:1];
          res_nxt.updated = 1'b1;
          state_nxt       = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      poles_r     <= POLES_RESET;
      tally_r     <= '0;
      gate_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      poles_r     <= poles_nxt;
      tally_r     <= tally_nxt;
      gate_r      <= gate_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r     <= now_nxt;
    elapsed_r <= elapsed_nxt;
    num_r     <= num_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the divider only runs while the sequencer waits on it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy || div_stat.done |-> state_r == S_DIV)
    else $error("divider active outside of divide state");

  // a gate restart always comes with a cleared tally
  assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(gate_r) |-> tally_r == '0)
    else $error("gate restarted without clearing the tally");

  // a result is loaded only once the previous one has left
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_ready)
    else $error("result loaded over an untaken word");

  // an updated result carries the freshly stored rpm
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_r.updated |-> res_r.rpm == prev_r)
    else $error("updated result differs from stored rpm");

endmodule
